### rtl/cnc_status_line_decoder_macros.svh
// Assertion helpers used by the decoder core.
`ifndef CNC_STATUS_LINE_DECODER_MACROS_SVH
`define CNC_STATUS_LINE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define CSLD_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define CSLD_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/csld_pkg.sv
// ----------------------------------------------------------------------------
// csld_pkg
// Shared types, character codes and tag tables for the status line decoder.
// ----------------------------------------------------------------------------
package csld_pkg;

    localparam int AXES    = 3;
    localparam int INT_W   = 34;
    localparam int TDATA_W = 328;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    // parser phases
    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_TAG       = 3'd1;
    localparam logic [2:0] PH_SKIP      = 3'd2;
    localparam logic [2:0] PH_VALUE     = 3'd3;
    localparam logic [2:0] PH_TEXT      = 3'd4;
    localparam logic [2:0] PH_TEXT_DONE = 3'd5;

    // line kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_ALARM  = 3'd1;
    localparam logic [2:0] KIND_ERROR  = 3'd2;
    localparam logic [2:0] KIND_MSG    = 3'd3;
    localparam logic [2:0] KIND_OTHER  = 3'd4;
    localparam logic [2:0] KIND_BAD    = 3'd5;

    // value token kinds
    localparam logic [1:0] VK_MPOS = 2'd0;
    localparam logic [1:0] VK_WPOS = 2'd1;
    localparam logic [1:0] VK_WCO  = 2'd2;
    localparam logic [1:0] VK_FS   = 2'd3;

    localparam logic [63:0] WORD_BOOT  = 64'h424F4F5400000000;
    localparam logic [63:0] WORD_ALARM = 64'h414C41524D000000;
    localparam logic [63:0] WORD_ERROR = 64'h4552524F52000000;

    typedef struct packed {
        logic       neg;
        logic       dot;
        logic       stop;
        logic       started;
        logic       rnd;
        logic       r5;
        logic [1:0] fd;
    } t_numfl;

    typedef struct packed {
        logic [3:0] mask;
        logic       hit;
        logic [1:0] idx;
    } t_match;

    typedef struct packed {
        logic [2:0]             kind;
        logic [63:0]            status;
        logic [AXES-1:0][31:0]  mach;
        logic [AXES-1:0][31:0]  work;
        logic [31:0]            feed;
        logic [31:0]            spin;
        logic                   spin_on;
    } t_result;

    // pattern text, right justified; txt selects the line-start table
    function automatic logic [39:0] pat_str(logic txt, logic [1:0] k);
        case ({txt, k})
            3'b000:  pat_str = "MPos:";
            3'b001:  pat_str = "WPos:";
            3'b010:  pat_str = "WCO:";
            3'b011:  pat_str = "FS:";
            3'b100:  pat_str = "ALARM";
            3'b101:  pat_str = "error";
            3'b110:  pat_str = "[MSG:";
            default: pat_str = '0;
        endcase
    endfunction

    function automatic logic [3:0] pat_len(logic txt, logic [1:0] k);
        case ({txt, k})
            3'b010:  pat_len = 4'd4;
            3'b011:  pat_len = 4'd3;
            3'b111:  pat_len = 4'd0;
            default: pat_len = 4'd5;
        endcase
    endfunction

    // one step of the prefix match over all live candidates
    function automatic t_match pat_match(logic txt, logic [3:0] mask, logic [3:0] pos,
                                         logic [7:0] c);
        t_match     m;
        logic [3:0] len;
        logic [5:0] sh;
        logic [39:0] s;
        m = '0;
        m.mask = mask;
        for (int i = 0; i < 4; i++) begin
            len = pat_len(txt, 2'(i));
            s   = pat_str(txt, 2'(i));
            sh  = 6'((len - 4'd1 - pos) << 3);
            if (mask[i]) begin
                if (pos < len && s[sh +: 8] == c) begin
                    if (pos + 4'd1 == len) begin
                        m.hit = 1'b1;
                        m.idx = 2'(i);
                    end
                end else begin
                    m.mask[i] = 1'b0;
                end
            end
        end
        return m;
    endfunction

endpackage

### rtl/cnc_status_line_decoder.sv
// Path: a line feed byte passes from the input register through the parser into the result register on m_axis.
// Throughput: one byte per cycle, set by the single-pass parser between the input and
// result registers; a byte that ends a line waits only while the result register is full.
// Reset: synchronous, active low; parser at line start, positions, feed and speed zero,
// status word BOOT, both stream registers empty.
// ----------------------------------------------------------------------------
// cnc_status_line_decoder
// Decodes status, alarm, error and message lines from a motion controller serial link.
// ----------------------------------------------------------------------------
module cnc_status_line_decoder #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status_text, mach_x, mach_y, mach_z, work_x, work_y, work_z,
    // feed_rate, spindle_rpm, spindle_on, zero pad
    output logic [csld_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                   m_axis_tuser    // [2:0] line_kind
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              take;
    logic              fire;
    logic              out_free;
    csld_pkg::t_result res;

    csld_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_take        (take),
        .o_valid       (in_valid),
        .o_byte        (in_byte)
    );

    csld_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_byte     (in_byte),
        .i_out_free (out_free),
        .o_take     (take),
        .o_fire     (fire),
        .o_res      (res)
    );

    csld_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_res         (res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### rtl/csld_in_reg.sv
// ----------------------------------------------------------------------------
// csld_in_reg
// Input register for received bytes.
// ----------------------------------------------------------------------------
module csld_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign s_axis_tready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_byte        = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
        end
    end

endmodule

### rtl/csld_core.sv
// ----------------------------------------------------------------------------
// csld_core
// Per-byte line parser: tag matching, number accumulation, report commit.
// ----------------------------------------------------------------------------
`include "cnc_status_line_decoder_macros.svh"

module csld_core #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_fire,
    output csld_pkg::t_result o_res
);

    localparam int PW = POSITION_WIDTH;
    localparam int AW = PW + 1;
    localparam int NP = 3 * csld_pkg::AXES;
    localparam logic [AW-1:0] MILLI_MAX = {AW{1'b1}};
    localparam logic [AW:0]   MAG_LIM   = (AW+1)'(1) << (PW - 1);
    localparam logic [csld_pkg::INT_W-1:0] INT_MAX = {csld_pkg::INT_W{1'b1}};
    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

    logic [2:0]   r_phase, n_phase;
    logic         r_name_open, n_name_open;
    logic [63:0]  r_pstat, n_pstat;
    logic [3:0]   r_scount, n_scount;
    logic [3:0]   r_mask, n_mask;
    logic [3:0]   r_mpos, n_mpos;
    logic [1:0]   r_vkind, n_vkind;
    logic [3:0]   r_vidx, n_vidx;
    logic [2:0]   r_tkind, n_tkind;
    logic         r_close, n_close;
    logic [2:0]   r_seen, n_seen;
    logic [AW-1:0] r_milli, n_milli;
    logic [csld_pkg::INT_W-1:0] r_int, n_int;
    csld_pkg::t_numfl r_fl, n_fl;
    logic signed [PW-1:0] r_ppos [NP];
    logic signed [PW-1:0] n_ppos [NP];
    logic signed [31:0] r_pfeed, n_pfeed, r_pspin, n_pspin;
    logic signed [PW-1:0] r_mach [csld_pkg::AXES];
    logic signed [PW-1:0] n_mach [csld_pkg::AXES];
    logic signed [PW-1:0] r_work [csld_pkg::AXES];
    logic signed [PW-1:0] n_work [csld_pkg::AXES];
    logic [63:0]  r_status, n_status;
    logic signed [31:0] r_feed, n_feed, r_spin, n_spin;

    logic         needs_out;
    logic         take;
    logic [2:0]   res_kind;

    function automatic logic signed [PW-1:0] fin_coord(logic [AW-1:0] m,
                                                       csld_pkg::t_numfl f);
        logic [AW:0] mag;
        mag = (AW+1)'(m) + (AW+1)'(f.rnd);
        if (f.neg) begin
            return (mag > MAG_LIM) ? POS_MIN : PW'(-mag);
        end
        return (mag > MAG_LIM - (AW+1)'(1)) ? POS_MAX : PW'(mag);
    endfunction

    function automatic logic signed [31:0] fin_fs(logic [csld_pkg::INT_W-1:0] w,
                                                  csld_pkg::t_numfl f);
        logic [csld_pkg::INT_W:0] whole;
        whole = (csld_pkg::INT_W+1)'(w) + (csld_pkg::INT_W+1)'(f.r5);
        if (f.neg) begin
            return (whole > (csld_pkg::INT_W+1)'(64'h80000000)) ? 32'h80000000
                                                                : 32'(-whole);
        end
        return (whole > (csld_pkg::INT_W+1)'(64'h7FFFFFFF)) ? 32'h7FFFFFFF : whole[31:0];
    endfunction

    function automatic logic signed [PW-1:0] sat_sub(logic signed [PW-1:0] a,
                                                     logic signed [PW-1:0] b);
        logic [PW:0] diff;
        diff = {a[PW-1], a} - {b[PW-1], b};
        if (diff[PW] != diff[PW-1]) begin
            return diff[PW] ? POS_MIN : POS_MAX;
        end
        return diff[PW-1:0];
    endfunction

    always_comb begin
        logic [7:0]        c;
        csld_pkg::t_match  mt;
        logic [3:0]        d;
        logic [6:0]        w;
        logic [AW+4:0]     mm;
        logic [AW:0]       mf;
        logic [csld_pkg::INT_W+3:0] ii;
        logic              do_fin;
        logic              do_commit;
        logic [AW-1:0]     f_milli;
        logic [csld_pkg::INT_W-1:0] f_int;
        csld_pkg::t_numfl  f_fl;
        logic [1:0]        f_vkind;
        logic [3:0]        f_vidx;
        logic [3:0]        ci;

        n_phase = r_phase;  n_name_open = r_name_open;  n_pstat = r_pstat;
        n_scount = r_scount; n_mask = r_mask; n_mpos = r_mpos; n_vkind = r_vkind;
        n_vidx = r_vidx; n_tkind = r_tkind; n_close = r_close; n_seen = r_seen;
        n_milli = r_milli; n_int = r_int; n_fl = r_fl; n_ppos = r_ppos;
        n_pfeed = r_pfeed; n_pspin = r_pspin; n_mach = r_mach; n_work = r_work;
        n_status = r_status; n_feed = r_feed; n_spin = r_spin;

        c = i_byte; mt = '0; d = '0; w = '0; mm = '0; mf = '0; ii = '0;
        do_fin = 1'b0; do_commit = 1'b0; ci = '0;
        f_milli = r_milli; f_int = r_int; f_fl = r_fl; f_vkind = r_vkind; f_vidx = r_vidx;
        res_kind = csld_pkg::KIND_OTHER;

        needs_out = (i_byte == csld_pkg::CH_LF) && (r_phase != csld_pkg::PH_START);
        take      = i_valid && (!needs_out || i_out_free);

        if (take && c != csld_pkg::CH_CR) begin
            if (c != csld_pkg::CH_LF) begin
                if (r_phase == csld_pkg::PH_START && c == csld_pkg::CH_LT) begin
                    n_name_open = 1'b1;
                    n_pstat     = '0;
                    n_scount    = '0;
                    n_seen      = '0;
                    for (int j = 0; j < NP; j++) n_ppos[j] = '0;
                    n_pfeed = r_feed;
                    n_pspin = r_spin;
                    n_close = 1'b0;
                    n_phase = csld_pkg::PH_TAG;
                    n_mask  = 4'hF;
                    n_mpos  = '0;
                end else begin
                    if (r_phase == csld_pkg::PH_START) begin
                        n_phase = csld_pkg::PH_TEXT;
                        n_tkind = csld_pkg::KIND_OTHER;
                        n_mask  = 4'b0111;
                        n_mpos  = '0;
                    end
                    if (n_phase == csld_pkg::PH_TEXT) begin
                        mt = csld_pkg::pat_match(1'b1, n_mask, n_mpos, c);
                        n_mask = mt.mask;
                        if (n_mpos < 4'd8) n_mpos = n_mpos + 4'd1;
                        if (mt.hit) begin
                            n_tkind = 3'(mt.idx) + 3'd1;
                            n_phase = csld_pkg::PH_TEXT_DONE;
                        end else if (mt.mask == '0) begin
                            n_tkind = csld_pkg::KIND_OTHER;
                            n_phase = csld_pkg::PH_TEXT_DONE;
                        end
                    end else if (n_phase != csld_pkg::PH_TEXT_DONE) begin
                        // a held '>' turned out not to close the line
                        if (r_close) begin
                            n_close = 1'b0;
                            if (n_name_open && n_scount < 4'd8) begin
                                n_pstat[(3'd7 - n_scount[2:0]) * 8 +: 8] = csld_pkg::CH_GT;
                                n_scount = n_scount + 4'd1;
                            end
                            if (n_phase == csld_pkg::PH_TAG) begin
                                n_phase = csld_pkg::PH_SKIP;
                                n_mask  = '0;
                                if (n_mpos < 4'd8) n_mpos = n_mpos + 4'd1;
                            end else if (n_phase == csld_pkg::PH_VALUE) begin
                                n_fl.stop = 1'b1;
                            end
                        end
                        if (c == csld_pkg::CH_GT) begin
                            n_close = 1'b1;
                        end else begin
                            if (n_name_open) begin
                                if (c == csld_pkg::CH_BAR) begin
                                    n_name_open = 1'b0;
                                end else if (n_scount < 4'd8) begin
                                    n_pstat[(3'd7 - n_scount[2:0]) * 8 +: 8] = c;
                                    n_scount = n_scount + 4'd1;
                                end
                            end
                            unique case (n_phase)
                                csld_pkg::PH_TAG: begin
                                    if (c == csld_pkg::CH_BAR) begin
                                        n_mask = 4'hF;
                                        n_mpos = '0;
                                    end else begin
                                        mt = csld_pkg::pat_match(1'b0, n_mask, n_mpos, c);
                                        n_mask = mt.mask;
                                        if (n_mpos < 4'd8) n_mpos = n_mpos + 4'd1;
                                        if (mt.hit) begin
                                            if (mt.idx != csld_pkg::VK_FS) begin
                                                n_seen[mt.idx] = 1'b1;
                                            end else begin
                                                n_pfeed = '0;
                                                n_pspin = '0;
                                            end
                                            for (int j = 0; j < NP; j++) begin
                                                if ((j / csld_pkg::AXES) == int'(mt.idx)) begin
                                                    n_ppos[j] = '0;
                                                end
                                            end
                                            n_vkind = mt.idx;
                                            n_vidx  = '0;
                                            n_milli = '0;
                                            n_int   = '0;
                                            n_fl    = '0;
                                            n_phase = csld_pkg::PH_VALUE;
                                        end else if (mt.mask == '0) begin
                                            n_phase = csld_pkg::PH_SKIP;
                                        end
                                    end
                                end
                                csld_pkg::PH_SKIP: begin
                                    if (c == csld_pkg::CH_BAR) begin
                                        n_phase = csld_pkg::PH_TAG;
                                        n_mask  = 4'hF;
                                        n_mpos  = '0;
                                    end
                                end
                                csld_pkg::PH_VALUE: begin
                                    if (c == csld_pkg::CH_COMMA || c == csld_pkg::CH_BAR) begin
                                        do_fin  = 1'b1;
                                        f_milli = n_milli;
                                        f_int   = n_int;
                                        f_fl    = n_fl;
                                        f_vkind = n_vkind;
                                        f_vidx  = n_vidx;
                                        n_milli = '0;
                                        n_int   = '0;
                                        n_fl    = '0;
                                        if (c == csld_pkg::CH_COMMA) begin
                                            if (n_vidx != 4'd15) n_vidx = n_vidx + 4'd1;
                                        end else begin
                                            n_phase = csld_pkg::PH_TAG;
                                            n_mask  = 4'hF;
                                            n_mpos  = '0;
                                        end
                                    end else if (!n_fl.stop) begin
                                        if (c >= csld_pkg::CH_0 && c <= csld_pkg::CH_9) begin
                                            d = c[3:0];
                                            n_fl.started = 1'b1;
                                            if (n_fl.dot) begin
                                                if (n_fl.fd != 2'd3) begin
                                                    w = (n_fl.fd == 2'd0) ? 7'd100 :
                                                        (n_fl.fd == 2'd1) ? 7'd10 : 7'd1;
                                                    mf = (AW+1)'(n_milli) +
                                                         (AW+1)'(d) * (AW+1)'(w);
                                                    n_milli = (mf > (AW+1)'(MILLI_MAX)) ?
                                                              MILLI_MAX : mf[AW-1:0];
                                                    if (n_fl.fd == 2'd0) n_fl.r5 = (d >= 4'd5);
                                                    n_fl.fd = n_fl.fd + 2'd1;
                                                end else begin
                                                    if (d >= 4'd5) n_fl.rnd = 1'b1;
                                                    n_fl.stop = 1'b1;
                                                end
                                            end else begin
                                                mm = (AW+5)'(n_milli) * (AW+5)'(10) +
                                                     (AW+5)'(d) * (AW+5)'(1000);
                                                n_milli = (mm > (AW+5)'(MILLI_MAX)) ?
                                                          MILLI_MAX : mm[AW-1:0];
                                                ii = (csld_pkg::INT_W+4)'(n_int) *
                                                     (csld_pkg::INT_W+4)'(10) +
                                                     (csld_pkg::INT_W+4)'(d);
                                                n_int = (ii > (csld_pkg::INT_W+4)'(INT_MAX)) ?
                                                        INT_MAX : ii[csld_pkg::INT_W-1:0];
                                            end
                                        end else if (!n_fl.started &&
                                                     (c == csld_pkg::CH_SP ||
                                                      c == csld_pkg::CH_TAB ||
                                                      c == csld_pkg::CH_VT ||
                                                      c == csld_pkg::CH_FF)) begin
                                            n_fl.stop = 1'b0; // leading blank
                                        end else if (!n_fl.started &&
                                                     (c == csld_pkg::CH_PLUS ||
                                                      c == csld_pkg::CH_MINUS)) begin
                                            n_fl.started = 1'b1;
                                            if (c == csld_pkg::CH_MINUS) n_fl.neg = 1'b1;
                                        end else if (c == csld_pkg::CH_DOT && !n_fl.dot) begin
                                            n_fl.dot     = 1'b1;
                                            n_fl.started = 1'b1;
                                        end else begin
                                            n_fl.stop = 1'b1;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end else if (r_phase != csld_pkg::PH_START) begin
                if (r_phase == csld_pkg::PH_TEXT || r_phase == csld_pkg::PH_TEXT_DONE) begin
                    res_kind = r_tkind;
                    if (r_tkind == csld_pkg::KIND_ALARM) n_status = csld_pkg::WORD_ALARM;
                    if (r_tkind == csld_pkg::KIND_ERROR) n_status = csld_pkg::WORD_ERROR;
                end else if (r_close) begin
                    res_kind  = csld_pkg::KIND_STATUS;
                    do_commit = 1'b1;
                    do_fin    = (r_phase == csld_pkg::PH_VALUE);
                end else begin
                    res_kind = csld_pkg::KIND_BAD;
                end
                n_phase = csld_pkg::PH_START;
                n_close = 1'b0;
            end
        end

        // close out the value that was being read
        if (do_fin) begin
            if (f_vkind != csld_pkg::VK_FS) begin
                ci = 4'(f_vkind) * 4'd3 + f_vidx;
                if (f_vidx < 4'd3) begin
                    for (int j = 0; j < NP; j++) begin
                        if (ci == 4'(j)) n_ppos[j] = fin_coord(f_milli, f_fl);
                    end
                end
            end else if (f_vidx == 4'd0) begin
                n_pfeed = fin_fs(f_int, f_fl);
            end else if (f_vidx == 4'd1) begin
                n_pspin = fin_fs(f_int, f_fl);
            end
        end

        if (do_commit) begin
            for (int i = 0; i < csld_pkg::AXES; i++) begin
                if (n_seen[0]) n_mach[i] = n_ppos[i];
            end
            for (int i = 0; i < csld_pkg::AXES; i++) begin
                if (n_seen[1]) begin
                    n_work[i] = n_ppos[csld_pkg::AXES + i];
                end else if (n_seen[0]) begin
                    n_work[i] = sat_sub(n_mach[i],
                                        n_seen[2] ? n_ppos[2*csld_pkg::AXES + i] : '0);
                end
            end
            n_feed   = n_pfeed;
            n_spin   = n_pspin;
            n_status = n_pstat;
        end

        o_res.kind   = res_kind;
        o_res.status = n_status;
        for (int i = 0; i < csld_pkg::AXES; i++) begin
            o_res.mach[i] = 32'(n_mach[i]);
            o_res.work[i] = 32'(n_work[i]);
        end
        o_res.feed    = n_feed;
        o_res.spin    = n_spin;
        o_res.spin_on = (n_spin > 32'sd0);
    end

    assign o_take = take;
    assign o_fire = take && needs_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= csld_pkg::PH_START;  r_name_open <= 1'b0;  r_pstat <= '0;
            r_scount <= '0;  r_mask <= '0;  r_mpos <= '0;  r_vkind <= '0;  r_vidx <= '0;
            r_tkind <= csld_pkg::KIND_OTHER;  r_close <= 1'b0;  r_seen <= '0;
            r_milli <= '0;  r_int <= '0;  r_fl <= '0;
            for (int j = 0; j < NP; j++) r_ppos[j] <= '0;
            r_pfeed <= '0;  r_pspin <= '0;
            for (int i = 0; i < csld_pkg::AXES; i++) begin
                r_mach[i] <= '0;
                r_work[i] <= '0;
            end
            r_status <= csld_pkg::WORD_BOOT;  r_feed <= '0;  r_spin <= '0;
        end else if (take) begin
            r_phase <= n_phase;  r_name_open <= n_name_open;  r_pstat <= n_pstat;
            r_scount <= n_scount;  r_mask <= n_mask;  r_mpos <= n_mpos;
            r_vkind <= n_vkind;  r_vidx <= n_vidx;  r_tkind <= n_tkind;
            r_close <= n_close;  r_seen <= n_seen;
            r_milli <= n_milli;  r_int <= n_int;  r_fl <= n_fl;
            r_ppos <= n_ppos;  r_pfeed <= n_pfeed;  r_pspin <= n_pspin;
            r_mach <= n_mach;  r_work <= n_work;
            r_status <= n_status;  r_feed <= n_feed;  r_spin <= n_spin;
        end
    end

    `CSLD_IMPLY(a_fire_on_lf, o_fire, i_byte == csld_pkg::CH_LF, "result without line feed")
    `CSLD_IMPLY(a_alarm_word, o_fire && o_res.kind == csld_pkg::KIND_ALARM, o_res.status == csld_pkg::WORD_ALARM, "alarm line without alarm word")
    `CSLD_NEXT(a_back_to_start, o_fire, r_phase == csld_pkg::PH_START, "parser not at line start after result")

endmodule

### rtl/csld_out_reg.sv
// ----------------------------------------------------------------------------
// csld_out_reg
// Result register and stream packing.
// ----------------------------------------------------------------------------
module csld_out_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  csld_pkg::t_result            i_res,
    output logic                         o_free,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status_text, mach_x, mach_y, mach_z, work_x, work_y, work_z,
    // feed_rate, spindle_rpm, spindle_on, zero pad
    output logic [csld_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                   m_axis_tuser   // [2:0] line_kind
);

    logic              r_valid;
    csld_pkg::t_result r_res;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tdata  = {7'd0, r_res.spin_on, r_res.spin, r_res.feed,
                            r_res.work[2], r_res.work[1], r_res.work[0],
                            r_res.mach[2], r_res.mach[1], r_res.mach[0], r_res.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds serial text lines into the status line decoder. The lines are status
// reports, alarm, error and message lines, other text and noise. A
// line-level model predicts each decoded line, and the decoded lines are
// checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [2:0]  kind;
        logic [63:0] status;
        logic [31:0] mach [3];
        logic [31:0] work [3];
        logic [31:0] feed;
        logic [31:0] spin;
        logic        spin_on;
    } t_line;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [7:0]   s_data = 8'h00;
    logic         m_ready = 1'b0;
    logic         s_ready, m_valid;
    logic [csld_pkg::TDATA_W-1:0] m_data;
    logic [2:0]   m_user;

    cnc_status_line_decoder uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user)
    );

    initial forever #1 i_clk = ~i_clk;

    // ---------------- line decoder model ----------------
    localparam longint unsigned ACC_CAP = (64'd1 << 52) - 1;
    localparam int P_START = 0, P_TAG = 1, P_SKIP = 2, P_VALUE = 3, P_TEXT = 4,
                   P_TEXT_DONE = 5;
    string tag_tab [4] = '{"MPos:", "WPos:", "WCO:", "FS:"};
    string line_tab [3] = '{"ALARM", "error", "[MSG:"};

    longint mach_pos [3], work_pos [3], held_vals [11];
    longint feed_val, spin_val;
    logic [63:0] word_now, word_held;
    bit [2:0] seen;
    int phase, word_cnt, mpos, vkind, vidx, tkind, frac_cnt;
    bit word_open, close_seen, n_neg, n_dot, n_stop, n_started, n_rnd;
    bit [3:0] mmask;
    longint unsigned accum;

    t_line decoded_q [$];
    int errors = 0, lines_seen = 0, bytes_sent = 0, reports_seen = 0;
    int long_hold = 0, idle_cnt = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned push_digit(longint unsigned a, int d);
        longint unsigned v;
        v = a * 10 + d;
        return (v > ACC_CAP) ? ACC_CAP : v;
    endfunction

    function automatic int match_next(bit txt, byte unsigned c);
        int done, n;
        string s;
        done = -1;
        n = txt ? 3 : 4;
        for (int i = 0; i < n; i++) begin
            if (!mmask[i]) continue;
            s = txt ? line_tab[i] : tag_tab[i];
            if (mpos < s.len() && byte'(s.getc(mpos)) == byte'(c)) begin
                if (mpos + 1 == s.len()) done = i;
            end else begin
                mmask[i] = 1'b0;
            end
        end
        if (mpos < 8) mpos++;
        return done;
    endfunction

    function automatic void clear_number();
        accum = 0;
        {n_neg, n_dot, n_stop, n_started, n_rnd} = '0;
        frac_cnt = 0;
    endfunction

    function automatic void open_token();
        phase = P_TAG;
        mmask = 4'hF;
        mpos = 0;
    endfunction

    function automatic void number_char(byte unsigned c);
        if (n_stop) return;
        if (c >= csld_pkg::CH_0 && c <= csld_pkg::CH_9) begin
            n_started = 1;
            if (n_dot) begin
                if (frac_cnt < 3) begin
                    accum = push_digit(accum, c - csld_pkg::CH_0);
                    frac_cnt++;
                end else begin
                    if (c - csld_pkg::CH_0 >= 5) n_rnd = 1;
                    n_stop = 1;
                end
            end else begin
                accum = push_digit(accum, c - csld_pkg::CH_0);
            end
        end else if (!n_started && (c == csld_pkg::CH_SP || c == csld_pkg::CH_TAB ||
                                    c == csld_pkg::CH_VT || c == csld_pkg::CH_FF)) begin
        end else if (!n_started && (c == csld_pkg::CH_PLUS || c == csld_pkg::CH_MINUS)) begin
            n_started = 1;
            if (c == csld_pkg::CH_MINUS) n_neg = 1;
        end else if (c == csld_pkg::CH_DOT && !n_dot) begin
            n_dot = 1;
            n_started = 1;
        end else begin
            n_stop = 1;
        end
    endfunction

    function automatic void store_value();
        int cnt, base;
        longint unsigned m, whole;
        longint v;
        cnt = (vkind < 3) ? 3 : 2;
        base = (vkind < 3) ? vkind * 3 : 9;
        if (vidx >= cnt) return;
        m = accum;
        for (int f = frac_cnt; f < 3; f++) m = push_digit(m, 0);
        if (vkind == 3) begin
            whole = m / 1000 + ((m % 1000 >= 500) ? 1 : 0);
            if (n_neg) v = (whole > 64'd2147483648) ? -64'sd2147483648 : -longint'(whole);
            else v = (whole > 64'd2147483647) ? 64'sd2147483647 : longint'(whole);
        end else begin
            if (n_rnd) m++;
            v = clamp32(n_neg ? -longint'(m) : longint'(m));
        end
        held_vals[base + vidx] = v;
    endfunction

    function automatic void report_char(byte unsigned c);
        int k, cnt, base;
        if (word_open) begin
            if (c == csld_pkg::CH_BAR) word_open = 0;
            else if (word_cnt < 8) begin
                word_held |= 64'(c) << (56 - 8 * word_cnt);
                word_cnt++;
            end
        end
        if (phase == P_TAG) begin
            if (c == csld_pkg::CH_BAR) begin
                open_token();
                return;
            end
            k = match_next(1'b0, c);
            if (k >= 0) begin
                cnt = (k < 3) ? 3 : 2;
                base = (k < 3) ? k * 3 : 9;
                if (k < 3) seen[k] = 1;
                for (int i = 0; i < cnt; i++) held_vals[base + i] = 0;
                vkind = k;
                vidx = 0;
                clear_number();
                phase = P_VALUE;
            end else if (mmask == 0) begin
                phase = P_SKIP;
            end
        end else if (phase == P_SKIP) begin
            if (c == csld_pkg::CH_BAR) open_token();
        end else begin
            if (c == csld_pkg::CH_COMMA) begin
                store_value();
                if (vidx < 15) vidx++;
                clear_number();
            end else if (c == csld_pkg::CH_BAR) begin
                store_value();
                open_token();
            end else begin
                number_char(c);
            end
        end
    endfunction

    function automatic void commit_report();
        longint off;
        if (phase == P_VALUE) store_value();
        if (seen[0]) for (int i = 0; i < 3; i++) mach_pos[i] = held_vals[i];
        if (seen[1]) begin
            for (int i = 0; i < 3; i++) work_pos[i] = held_vals[3 + i];
        end else if (seen[0]) begin
            for (int i = 0; i < 3; i++) begin
                off = seen[2] ? held_vals[6 + i] : 0;
                work_pos[i] = clamp32(mach_pos[i] - off);
            end
        end
        feed_val = held_vals[9];
        spin_val = held_vals[10];
        word_now = word_held;
    endfunction

    function automatic void decoder_reset();
        for (int i = 0; i < 3; i++) begin
            mach_pos[i] = 0;
            work_pos[i] = 0;
        end
        for (int i = 0; i < 11; i++) held_vals[i] = 0;
        word_now = csld_pkg::WORD_BOOT;
        word_held = 0;
        feed_val = 0;
        spin_val = 0;
        seen = 0;
        phase = P_START;
        clear_number();
        close_seen = 0;
        word_cnt = 0;
        word_open = 0;
        mmask = 0;
        mpos = 0;
        vkind = 0;
        vidx = 0;
        tkind = csld_pkg::KIND_OTHER;
    endfunction

    // returns 1 and the decoded line when the byte ends a non-empty line
    function automatic bit decode_byte(byte unsigned c, output t_line r);
        int k;
        logic [2:0] kind;
        r = '{default: '0};
        if (c == csld_pkg::CH_CR) return 0;
        if (c != csld_pkg::CH_LF) begin
            if (phase == P_START) begin
                if (c == csld_pkg::CH_LT) begin
                    word_open = 1;
                    word_held = 0;
                    word_cnt = 0;
                    seen = 0;
                    for (int i = 0; i < 11; i++) held_vals[i] = 0;
                    held_vals[9] = feed_val;
                    held_vals[10] = spin_val;
                    close_seen = 0;
                    open_token();
                    return 0;
                end
                phase = P_TEXT;
                tkind = csld_pkg::KIND_OTHER;
                mmask = 4'h7;
                mpos = 0;
            end
            if (phase == P_TEXT) begin
                k = match_next(1'b1, c);
                if (k >= 0) begin
                    tkind = k + 1;
                    phase = P_TEXT_DONE;
                end else if (mmask == 0) begin
                    tkind = csld_pkg::KIND_OTHER;
                    phase = P_TEXT_DONE;
                end
            end else if (phase != P_TEXT_DONE) begin
                if (close_seen) begin
                    close_seen = 0;
                    report_char(csld_pkg::CH_GT);
                end
                if (c == csld_pkg::CH_GT) close_seen = 1;
                else report_char(c);
            end
            return 0;
        end
        if (phase == P_START) return 0;
        if (phase == P_TEXT || phase == P_TEXT_DONE) begin
            kind = 3'(tkind);
            if (kind == csld_pkg::KIND_ALARM) word_now = csld_pkg::WORD_ALARM;
            else if (kind == csld_pkg::KIND_ERROR) word_now = csld_pkg::WORD_ERROR;
        end else if (close_seen) begin
            commit_report();
            kind = csld_pkg::KIND_STATUS;
        end else begin
            kind = csld_pkg::KIND_BAD;
        end
        phase = P_START;
        close_seen = 0;
        r.kind = kind;
        r.status = word_now;
        for (int i = 0; i < 3; i++) begin
            r.mach[i] = mach_pos[i][31:0];
            r.work[i] = work_pos[i][31:0];
        end
        r.feed = feed_val[31:0];
        r.spin = spin_val[31:0];
        r.spin_on = spin_val > 0;
        return 1;
    endfunction

    // ---------------- sender ----------------
    // tvalid stays high after an accept; the next item or the end of the run replaces it
    task automatic send_byte(byte unsigned b);
        int gap;
        t_line r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge i_clk); while (!s_ready);
        bytes_sent++;
        if (decode_byte(b, r)) decoded_q.push_back(r);
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s.getc(i));
        if ($urandom_range(0, 4) == 0) send_byte(csld_pkg::CH_CR);
        send_byte(csld_pkg::CH_LF);
    endtask

    // ---------------- receiver ----------------
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                long_hold--;
            end else if (m_valid && m_ready) begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
                m_ready <= (stall == 0);
            end else if (stall > 1) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                stall = 0;
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        t_line e;
        bit bad;
        if (i_rst_n && m_valid && m_ready) begin
            lines_seen++;
            if (m_user == csld_pkg::KIND_STATUS) reports_seen++;
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected line kind=%0d", m_user);
            end else begin
                e = decoded_q.pop_front();
                bad = (m_user !== e.kind) || (m_data[63:0] !== e.status)
                    || (m_data[287:256] !== e.feed) || (m_data[319:288] !== e.spin)
                    || (m_data[320] !== e.spin_on) || (m_data[327:321] !== 7'd0);
                for (int i = 0; i < 3; i++)
                    bad |= (m_data[64 + 32 * i +: 32] !== e.mach[i])
                        || (m_data[160 + 32 * i +: 32] !== e.work[i]);
                if (bad) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch line %0d: exp kind=%0d st=%h m=%h,%h,%h",
                                 lines_seen, e.kind, e.status, e.mach[0], e.mach[1],
                                 e.mach[2]);
                        $display("    w=%h,%h,%h f=%h s=%h on=%b",
                                 e.work[0], e.work[1], e.work[2], e.feed, e.spin,
                                 e.spin_on);
                        $display("    got kind=%0d data=%h", m_user, m_data);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 4000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------- line generators ----------------
    function automatic string rand_number();
        string s;
        int nd;
        s = "";
        if ($urandom_range(0, 5) == 0) s = {s, ($urandom_range(0, 1) ? " " : "\t")};
        case ($urandom_range(0, 3))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
        endcase
        nd = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 18) : $urandom_range(0, 4);
        for (int i = 0; i < nd; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        if ($urandom_range(0, 2) != 0) begin
            s = {s, "."};
            nd = $urandom_range(0, 6);
            for (int i = 0; i < nd; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        if ($urandom_range(0, 12) == 0) s = {s, "e3"};
        return s;
    endfunction

    function automatic string rand_values(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, (i > 0) ? "," : "", rand_number()};
        return s;
    endfunction

    function automatic string rand_report();
        string words [7] = '{"Idle", "Run", "Hold:0", "Jog", "Door:1", "Alarm", "CheckModeX"};
        string others [5] = '{"Bf:15,128", "Ov:100,100,100", "Pn:XYZ", "MPo", "F:300"};
        string s;
        int nt;
        s = {"<", words[$urandom_range(0, 6)]};
        nt = $urandom_range(0, 4);
        for (int i = 0; i < nt; i++) begin
            case ($urandom_range(0, 5))
                0, 1: s = {s, "|MPos:", rand_values($urandom_range(0, 4))};
                2: s = {s, "|WPos:", rand_values($urandom_range(0, 4))};
                3: s = {s, "|WCO:", rand_values($urandom_range(0, 4))};
                4: s = {s, "|FS:", rand_values($urandom_range(0, 3))};
                default: s = {s, "|", others[$urandom_range(0, 4)]};
            endcase
        end
        case ($urandom_range(0, 9))
            0: ;
            1: s = {s, ">x"};
            2: s = {s, ">>"};
            default: s = {s, ">"};
        endcase
        return s;
    endfunction

    function automatic string rand_noise();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(0, 255)))};
        return s;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_line("<Idle|MPos:1.0005,-2.0004,3|FS:500.5,-12000.4999>");
        send_line("<Run|MPos:99999999,-99999999,1.9995|WCO:-99999999,5,x>");
        send_line("<Jog|WPos:1,2,3|FS:3000000000,-3000000000>");
        send_line("<Hold:0|MPos: \t+.5e3,,|Ov:1|MPos:7,8,9,10|FS:-.5,.4995,7>");
        send_line("<VeryLongWord|FS:0>");
        send_line("ALARM:1");
        send_line("error:20");
        send_line("[MSG:Reset to continue]");
        send_line("ok");
        send_line("<Idle|MPos:1,2");
        send_line("\r\r");
        send_line("<>");
        send_line("<|WCO:1,1,1>z>");
        send_line({"\x00", "AL"});
        send_line("<Door|MPos:99999999999999999999,-99999999999999999999,0>");
        send_line("<Idle|WCO:1|MPos:-2147483.648,2147483.647,5>");
    endtask

    task automatic test_random(int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            case ($urandom_range(0, 9))
                0: send_line(rand_noise());
                1: send_line($urandom_range(0, 1) ? "ALARM:3" : "error:9");
                2: send_line($urandom_range(0, 1) ? "[MSG:x]" : "ALAR");
                3: send_line($urandom_range(0, 1) ? "" : rand_report().substr(0, 5));
                default: send_line(rand_report());
            endcase
        end
    endtask

    task automatic test_backpressure();
        long_hold = 400;
        for (int i = 0; i < 20; i++) send_line($urandom_range(0, 1) ? "ok" : "<Run|FS:1,2>");
    endtask

    initial begin
        decoder_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        test_backpressure();
        test_random(200);
        s_valid <= 1'b0;
        while (decoded_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("sent %0d bytes, checked %0d lines (%0d status reports)",
                 bytes_sent, lines_seen, reports_seen);
        $display("covered reports, alarm/error/message/other text, noise and a long stall");
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
